/* sv/isr_pkg.sv */
// Shared types for the integer square root pipeline.
`timescale 1ns / 1ps

package isr_pkg;

    typedef struct packed {
        logic valid;
        logic neg;
    } ctrl_t;

endpackage

/* sv/integer_square_root_top.sv */
// Pipelined integer square root: one digit step per stage, (VALUE_WIDTH+1)/2 stages.
// Throughput: one item per cycle; busy stays low, the stage chain never stalls.
// Reset clears the valid bits of every stage; data registers are not reset.
// Results appear for one cycle on root with done high; the receiver cannot stall.
`timescale 1ns / 1ps

module integer_square_root_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [VALUE_WIDTH-1:0] value,
    output logic                          done,
    output logic signed [VALUE_WIDTH/2:0] root
);

    localparam int NP = (VALUE_WIDTH + 1) / 2;
    localparam int PW = 2 * NP;
    localparam int RW = NP + 2;
    localparam int ROOT_WIDTH = VALUE_WIDTH / 2 + 1;

    isr_pkg::ctrl_t ctrl_s [0:NP];
    logic [PW-1:0]  val_s  [0:NP];
    logic [RW-1:0]  rem_s  [0:NP];
    logic [NP-1:0]  root_s [0:NP];

    assign busy = 1'b0;

    assign ctrl_s[0].valid = start && !busy;
    assign ctrl_s[0].neg   = value[VALUE_WIDTH-1];
    assign val_s[0]        = PW'($unsigned(value));
    assign rem_s[0]        = '0;
    assign root_s[0]       = '0;

    for (genvar i = 0; i < NP; i++)
    begin : g_stage
        isr_stage #(
            .NP (NP)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_s[i]),
            .val_in   (val_s[i]),
            .rem_in   (rem_s[i]),
            .root_in  (root_s[i]),
            .ctrl_out (ctrl_s[i+1]),
            .val_out  (val_s[i+1]),
            .rem_out  (rem_s[i+1]),
            .root_out (root_s[i+1])
        );
    end

    assign done = ctrl_s[NP].valid;
    assign root = ctrl_s[NP].neg ? {ROOT_WIDTH{1'b1}} : ROOT_WIDTH'(root_s[NP]);

    a_done_follows_start : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, NP))
        else $error("done without matching start");

    a_sign_matches_value : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (root[ROOT_WIDTH-1] == $past(value[VALUE_WIDTH-1], NP)))
        else $error("root sign does not match item sign");

    a_negative_all_ones : assert property (@(posedge clk) disable iff (!rst_n)
        (done && root[ROOT_WIDTH-1]) |-> (root == {ROOT_WIDTH{1'b1}}))
        else $error("negative item did not give all ones");

endmodule

/* sv/isr_stage.sv */
// One restoring digit step of the square root pipeline, registered.
`timescale 1ns / 1ps

module isr_stage #(
    parameter int NP = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  isr_pkg::ctrl_t       ctrl_in,
    input  logic [2*NP-1:0]      val_in,
    input  logic [NP+1:0]        rem_in,
    input  logic [NP-1:0]        root_in,
    output isr_pkg::ctrl_t       ctrl_out,
    output logic [2*NP-1:0]      val_out,
    output logic [NP+1:0]        rem_out,
    output logic [NP-1:0]        root_out
);

    localparam int PW = 2 * NP;
    localparam int RW = NP + 2;

    isr_pkg::ctrl_t  ctrl_reg;
    logic [PW-1:0]   val_reg;
    logic [PW-1:0]   val_next;
    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   rem_next;
    logic [NP-1:0]   root_reg;
    logic [NP-1:0]   root_next;
    logic [RW-1:0]   cur;
    logic [RW-1:0]   trial;
    logic            take;

    always_comb
    begin
        cur       = {rem_in[RW-3:0], val_in[PW-1:PW-2]};
        trial     = {root_in, 2'b01};
        take      = (cur >= trial);
        rem_next  = take ? (cur - trial) : cur;
        root_next = {root_in[NP-2:0], take};
        val_next  = {val_in[PW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign ctrl_out = ctrl_reg;
    assign val_out  = val_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

/* dv/integer_square_root_top_test.sv */
// Self-checking testbench for the pipelined integer square root block.
`timescale 1ns / 1ps

module integer_square_root_top_test;

    localparam int VALUE_WIDTH    = 32;
    localparam int ROOT_WIDTH     = VALUE_WIDTH / 2 + 1;
    localparam int PIPE_LATENCY   = (VALUE_WIDTH + 1) / 2;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CALM_FIRST     = 400;
    localparam int CALM_LAST      = 650;
    localparam int DRAIN_MARK     = 700;
    localparam longint MAX_VALUE  = 64'sh7fff_ffff;

    logic                          clk   = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic signed [VALUE_WIDTH-1:0] value = '0;
    logic                          busy;
    logic                          done;
    logic signed [ROOT_WIDTH-1:0]  root;

    logic signed [VALUE_WIDTH-1:0] pending_values[$];
    logic signed [ROOT_WIDTH-1:0]  expected_roots[$];
    int                            sent_count     = 0;
    int                            directed_count = 0;
    int                            mismatch_count = 0;
    int                            quiet_cycles   = 0;
    bit                            idle_now;
    bit                            draining;

    integer_square_root_top #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .value(value),
        .done (done),
        .root (root)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic signed [ROOT_WIDTH-1:0] predict_root(
        input logic signed [VALUE_WIDTH-1:0] v);
        longint unsigned mag;
        longint unsigned acc;
        longint unsigned trial;
        begin
            if (v < 0)
                return '1;
            mag = longint'(v);
            acc = 0;
            for (int b = ROOT_WIDTH - 1; b >= 0; b--)
            begin
                trial = acc | (longint'(1) << b);
                if (trial * trial <= mag)
                    acc = trial;
            end
            return acc[ROOT_WIDTH-1:0];
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            value <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_roots.push_back(predict_root(value));
                sent_count = sent_count + 1;
            end
            if (!(start && busy))
            begin
                idle_now = ($urandom_range(0, 99) < 30)
                    && !(sent_count >= CALM_FIRST && sent_count < CALM_LAST);
                draining = (sent_count == directed_count || sent_count == DRAIN_MARK)
                    && expected_roots.size() != 0;
                if (pending_values.size() != 0 && !idle_now && !draining)
                begin
                    start <= 1'b1;
                    value <= pending_values.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_roots.size() == 0)
            begin
                $error("unexpected result: root %0d", root);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                logic signed [ROOT_WIDTH-1:0] want;
                want = expected_roots.pop_front();
                if (root !== want)
                begin
                    $error("root mismatch: expected %0d, actual %0d", want, root);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        longint near;
        int     pick;
        pending_values.push_back(32'sd0);
        pending_values.push_back(32'sd1);
        pending_values.push_back(32'sd2);
        pending_values.push_back(32'sd3);
        pending_values.push_back(32'sd4);
        pending_values.push_back(32'sd15);
        pending_values.push_back(32'sd16);
        pending_values.push_back(32'sd17);
        pending_values.push_back(32'sd255);
        pending_values.push_back(32'sd256);
        pending_values.push_back(32'sh3fff_ffff);
        pending_values.push_back(32'sh4000_0000);
        pending_values.push_back(32'sd2147395599);
        pending_values.push_back(32'sd2147395600);
        pending_values.push_back(32'sh7fff_ffff);
        pending_values.push_back(32'sh5555_5555);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(-32'sd2);
        pending_values.push_back(32'sh8000_0000);
        pending_values.push_back(32'shaaaa_aaaa);
        directed_count = pending_values.size();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                pending_values.push_back($urandom);
            else if (pick < 6)
                pending_values.push_back($urandom_range(0, 1023));
            else if (pick < 8)
            begin
                // around a perfect square
                near = longint'($urandom_range(0, 46340));
                near = near * near + longint'($urandom_range(0, 2)) - 1;
                if (near < 0)
                    near = 0;
                if (near > MAX_VALUE)
                    near = MAX_VALUE;
                pending_values.push_back(near[VALUE_WIDTH-1:0]);
            end
            else if (pick < 9)
                pending_values.push_back($urandom >> $urandom_range(1, 31));
            else
                pending_values.push_back($urandom | 32'h8000_0000);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_values.size() != 0 || start || expected_roots.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        if (mismatch_count == 0 && expected_roots.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
